/* hw/rtl/yuv420_block_to_rgb565_unit_defines.svh */
// Assertion helpers shared by the converter modules.
`ifndef YUV420_BLOCK_TO_RGB565_UNIT_DEFINES_SVH
`define YUV420_BLOCK_TO_RGB565_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define YUV2RGB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("yuv2rgb assertion failed");

// Next-cycle implication, checked out of reset.
`define YUV2RGB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("yuv2rgb assertion failed");

`endif

/* hw/rtl/yuv2rgb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package yuv2rgb_pkg;

  localparam int unsigned COEF_SHIFT = 23;
  localparam int unsigned MULT_W     = 24;

  // Coefficients scaled by 2^23, rounded up; exact floor for magnitudes up to 128.
  localparam longint UB_MULT_L = (64'd1772  * (64'd1 << COEF_SHIFT) + 64'd999)   / 64'd1000;
  localparam longint UG_MULT_L = (64'd34414 * (64'd1 << COEF_SHIFT) + 64'd99999) / 64'd100000;
  localparam longint VG_MULT_L = (64'd71414 * (64'd1 << COEF_SHIFT) + 64'd99999) / 64'd100000;
  localparam longint VR_MULT_L = (64'd1402  * (64'd1 << COEF_SHIFT) + 64'd999)   / 64'd1000;

  localparam logic [MULT_W-1:0] UB_MULT = MULT_W'(UB_MULT_L);
  localparam logic [MULT_W-1:0] UG_MULT = MULT_W'(UG_MULT_L);
  localparam logic [MULT_W-1:0] VG_MULT = MULT_W'(VG_MULT_L);
  localparam logic [MULT_W-1:0] VR_MULT = MULT_W'(VR_MULT_L);

  localparam logic [7:0] CHROMA_OFFSET = 8'd128;

  typedef struct packed {
    logic [7:0] top_left;
    logic [7:0] top_right;
    logic [7:0] bottom_left;
    logic [7:0] bottom_right;
  } luma_quad_t;

  typedef struct packed {
    luma_quad_t         luma;
    logic signed [8:0]  ub;
    logic signed [8:0]  gsub;
    logic signed [8:0]  vr;
  } chroma_terms_t;

  function automatic logic [7:0] clamp8(input logic signed [10:0] x);
    logic [7:0] res;
    if (x < 0) begin
      res = 8'd0;
    end else if (x > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  function automatic logic [15:0] pack565(input logic [7:0] y,
                                          input logic signed [8:0] ub,
                                          input logic signed [8:0] gsub,
                                          input logic signed [8:0] vr);
    logic signed [10:0] ys;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    ys = $signed({3'b000, y});
    b  = clamp8(ys + 11'(ub));
    g  = clamp8(ys - 11'(gsub));
    r  = clamp8(ys + 11'(vr));
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/yuv2rgb_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface yuv2rgb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_top_left;
  logic [7:0] luma_top_right;
  logic [7:0] luma_bottom_left;
  logic [7:0] luma_bottom_right;
  logic [7:0] chroma_blue;
  logic [7:0] chroma_red;

  modport source (
    output valid, luma_top_left, luma_top_right, luma_bottom_left,
           luma_bottom_right, chroma_blue, chroma_red,
    input  ready
  );
  modport sink (
    input  valid, luma_top_left, luma_top_right, luma_bottom_left,
           luma_bottom_right, chroma_blue, chroma_red,
    output ready
  );
endinterface
`default_nettype wire

/* hw/rtl/yuv2rgb_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface yuv2rgb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] top_pair;
  logic [31:0] bottom_pair;

  modport source (
    output valid, top_pair, bottom_pair,
    input  ready
  );
  modport sink (
    input  valid, top_pair, bottom_pair,
    output ready
  );
endinterface
`default_nettype wire

/* hw/rtl/yuv2rgb_chroma.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "yuv420_block_to_rgb565_unit_defines.svh"
module yuv2rgb_chroma (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  yuv2rgb_in_if.sink                       in_ch,
  output logic                             terms_valid,
  input  wire logic                        terms_ready,
  output yuv2rgb_pkg::chroma_terms_t       terms
);
  import yuv2rgb_pkg::*;

  // Stage A: chroma offset removed, kept as sign and magnitude
  logic       a_valid_r;
  luma_quad_t a_luma_r;
  logic [7:0] a_cb_mag_r, a_cr_mag_r;
  logic       a_cb_neg_r, a_cr_neg_r;
  logic       a_ready;

  // Stage B: scaled magnitudes
  logic       b_valid_r;
  luma_quad_t b_luma_r;
  logic [8:0] b_ub_r, b_ug_r, b_vg_r, b_vr_r;
  logic       b_cb_neg_r, b_cr_neg_r;
  logic       b_ready;

  // Stage C: signed terms
  logic          c_valid_r;
  chroma_terms_t c_terms_r;
  logic          c_ready;

  logic [7:0] cb_mag, cr_mag;
  logic       cb_neg, cr_neg;
  logic [31:0] ub_prod, ug_prod, vg_prod, vr_prod;
  logic signed [8:0] ub_s, ug_s, vg_s, vr_s;
  chroma_terms_t c_terms_nxt;

  assign c_ready = !c_valid_r || terms_ready;
  assign b_ready = !b_valid_r || c_ready;
  assign a_ready = !a_valid_r || b_ready;
  assign in_ch.ready = a_ready;

  always_comb begin
    cb_neg = (in_ch.chroma_blue < CHROMA_OFFSET);
    cr_neg = (in_ch.chroma_red < CHROMA_OFFSET);
    cb_mag = cb_neg ? (CHROMA_OFFSET - in_ch.chroma_blue) : (in_ch.chroma_blue - CHROMA_OFFSET);
    cr_mag = cr_neg ? (CHROMA_OFFSET - in_ch.chroma_red) : (in_ch.chroma_red - CHROMA_OFFSET);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_ch.valid) begin
      a_luma_r.top_left     <= in_ch.luma_top_left;
      a_luma_r.top_right    <= in_ch.luma_top_right;
      a_luma_r.bottom_left  <= in_ch.luma_bottom_left;
      a_luma_r.bottom_right <= in_ch.luma_bottom_right;
      a_cb_mag_r <= cb_mag;
      a_cr_mag_r <= cr_mag;
      a_cb_neg_r <= cb_neg;
      a_cr_neg_r <= cr_neg;
    end
  end

  always_comb begin
    ub_prod = 32'({24'd0, a_cb_mag_r} * {8'd0, UB_MULT});
    ug_prod = 32'({24'd0, a_cb_mag_r} * {8'd0, UG_MULT});
    vg_prod = 32'({24'd0, a_cr_mag_r} * {8'd0, VG_MULT});
    vr_prod = 32'({24'd0, a_cr_mag_r} * {8'd0, VR_MULT});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  // Keep only the integer part of each product: truncation of the magnitude
  always_ff @(posedge clk) begin
    if (b_ready && a_valid_r) begin
      b_luma_r   <= a_luma_r;
      b_ub_r     <= ub_prod[COEF_SHIFT +: 9];
      b_ug_r     <= ug_prod[COEF_SHIFT +: 9];
      b_vg_r     <= vg_prod[COEF_SHIFT +: 9];
      b_vr_r     <= vr_prod[COEF_SHIFT +: 9];
      b_cb_neg_r <= a_cb_neg_r;
      b_cr_neg_r <= a_cr_neg_r;
    end
  end

  always_comb begin
    ub_s = b_cb_neg_r ? -$signed(b_ub_r) : $signed(b_ub_r);
    ug_s = b_cb_neg_r ? -$signed(b_ug_r) : $signed(b_ug_r);
    vg_s = b_cr_neg_r ? -$signed(b_vg_r) : $signed(b_vg_r);
    vr_s = b_cr_neg_r ? -$signed(b_vr_r) : $signed(b_vr_r);
    c_terms_nxt.luma = b_luma_r;
    c_terms_nxt.ub   = ub_s;
    c_terms_nxt.gsub = ug_s + vg_s;
    c_terms_nxt.vr   = vr_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (c_ready) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_valid_r) begin
      c_terms_r <= c_terms_nxt;
    end
  end

  assign terms_valid = c_valid_r;
  assign terms       = c_terms_r;

  `YUV2RGB_ASSERT_NOW(a_ub_range, c_valid_r,
    (c_terms_r.ub >= -9'sd226) && (c_terms_r.ub <= 9'sd225))
  `YUV2RGB_ASSERT_NOW(a_gsub_range, c_valid_r,
    (c_terms_r.gsub >= -9'sd135) && (c_terms_r.gsub <= 9'sd135))
  `YUV2RGB_ASSERT_NEXT(a_mid_advance, b_valid_r && c_ready, c_valid_r)

endmodule
`default_nettype wire

/* hw/rtl/yuv2rgb_pack.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "yuv420_block_to_rgb565_unit_defines.svh"
module yuv2rgb_pack (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire yuv2rgb_pkg::chroma_terms_t  in_terms,
  yuv2rgb_out_if.source                    out_ch
);
  import yuv2rgb_pkg::*;

  logic        out_valid_r;
  logic [31:0] top_pair_r, bottom_pair_r;
  logic [31:0] top_pair_nxt, bottom_pair_nxt;

  assign in_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    top_pair_nxt = {pack565(in_terms.luma.top_right, in_terms.ub, in_terms.gsub, in_terms.vr),
                    pack565(in_terms.luma.top_left, in_terms.ub, in_terms.gsub, in_terms.vr)};
    bottom_pair_nxt = {
      pack565(in_terms.luma.bottom_right, in_terms.ub, in_terms.gsub, in_terms.vr),
      pack565(in_terms.luma.bottom_left, in_terms.ub, in_terms.gsub, in_terms.vr)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      top_pair_r    <= top_pair_nxt;
      bottom_pair_r <= bottom_pair_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.top_pair    = top_pair_r;
  assign out_ch.bottom_pair = bottom_pair_r;

  `YUV2RGB_ASSERT_NEXT(a_load_valid, in_valid && in_ready, out_valid_r)

endmodule
`default_nettype wire

/* hw/rtl/yuv420_block_to_rgb565_unit.sv */
// YUV420 2x2 block to RGB565 converter, four register stages.
// Each accepted request passes through chroma stages A, B, C and the pack output register.
// Throughput: one block per cycle; each stage holds its item while downstream stalls.
// Reset: synchronous active-low rst_n clears the stage valid bits; data regs not reset.
`timescale 1ns / 1ps
`default_nettype none
module yuv420_block_to_rgb565_unit (
  input  wire logic     clk,
  input  wire logic     rst_n,
  yuv2rgb_in_if.sink    in_blk,
  yuv2rgb_out_if.source out_blk
);
  import yuv2rgb_pkg::*;

  logic          terms_valid;
  logic          terms_ready;
  chroma_terms_t terms;

  yuv2rgb_chroma u_chroma (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_blk),
    .terms_valid (terms_valid),
    .terms_ready (terms_ready),
    .terms       (terms)
  );

  yuv2rgb_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (terms_valid),
    .in_ready (terms_ready),
    .in_terms (terms),
    .out_ch   (out_blk)
  );

endmodule
`default_nettype wire

/* dv/yuv420_block_to_rgb565_unit_tb.sv */
`timescale 1ns / 1ps
module yuv420_block_to_rgb565_unit_tb;

  localparam int HOLD_OFF_CYCLES = 200;
  localparam int QUIET_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int CHROMA_BIAS     = 128;
  localparam int MAX_REPORTS     = 20;

  typedef struct packed {
    logic [7:0] ytl;
    logic [7:0] ytr;
    logic [7:0] ybl;
    logic [7:0] ybr;
    logic [7:0] cb;
    logic [7:0] cr;
  } block_t;

  typedef struct packed {
    logic [31:0] top_pair;
    logic [31:0] bottom_pair;
  } rgb_pairs_t;

  class rgb565_tracker;
    rgb_pairs_t pending_pairs[$];
    int blocks_in;
    int pairs_out;
    int errors;

    function int signed chroma_term(int signed c, int num, int den);
      int signed mag;
      int signed q;
      mag = (c < 0) ? -c : c;
      q   = (mag * num) / den;
      return (c < 0) ? -q : q;
    endfunction

    function logic [7:0] sat8(int signed x);
      if (x < 0) return 8'd0;
      if (x > 255) return 8'd255;
      return x[7:0];
    endfunction

    function logic [15:0] to_rgb565(logic [7:0] y, int signed ub, int signed gsub,
                                    int signed vr);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      int signed yi;
      yi = int'(y);
      b  = sat8(yi + ub);
      g  = sat8(yi - gsub);
      r  = sat8(yi + vr);
      return {r[7:3], g[7:2], b[7:3]};
    endfunction

    function rgb_pairs_t convert_block(block_t blk);
      int signed cb;
      int signed cr;
      int signed ub;
      int signed gsub;
      int signed vr;
      rgb_pairs_t res;
      cb   = int'(blk.cb) - CHROMA_BIAS;
      cr   = int'(blk.cr) - CHROMA_BIAS;
      ub   = chroma_term(cb, 1772, 1000);
      // green takes both chroma terms, each truncated on its own
      gsub = chroma_term(cb, 34414, 100000) + chroma_term(cr, 71414, 100000);
      vr   = chroma_term(cr, 1402, 1000);
      res.top_pair    = {to_rgb565(blk.ytr, ub, gsub, vr), to_rgb565(blk.ytl, ub, gsub, vr)};
      res.bottom_pair = {to_rgb565(blk.ybr, ub, gsub, vr), to_rgb565(blk.ybl, ub, gsub, vr)};
      return res;
    endfunction

    function void note_block(block_t blk);
      pending_pairs.push_back(convert_block(blk));
      blocks_in++;
    endfunction

    function void report(string what, logic [31:0] exp_val, logic [31:0] act_val);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_val, act_val);
    endfunction

    function void check_pairs(logic [31:0] top_pair, logic [31:0] bottom_pair);
      rgb_pairs_t exp_pairs;
      pairs_out++;
      if (pending_pairs.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with no request pending, expected none, got %h %h",
                   $time, top_pair, bottom_pair);
        return;
      end
      exp_pairs = pending_pairs.pop_front();
      if (top_pair !== exp_pairs.top_pair) report("top_pair", exp_pairs.top_pair, top_pair);
      if (bottom_pair !== exp_pairs.bottom_pair)
        report("bottom_pair", exp_pairs.bottom_pair, bottom_pair);
    endfunction

    function int pending_count();
      return pending_pairs.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  yuv2rgb_in_if  in_blk();
  yuv2rgb_out_if out_blk();

  yuv420_block_to_rgb565_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_blk  (in_blk.sink),
    .out_blk (out_blk.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rgb565_tracker book = new();
  int tx_idle_max;
  int rx_idle_max;
  int hold_cycles;
  int quiet_cycles;

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 3))
      0: return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7))
                                            : 8'($urandom_range(248, 255));
      1: return 8'($urandom_range(120, 136));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic block_t pick_block();
    block_t blk;
    blk.ytl = pick_sample();
    blk.ytr = pick_sample();
    blk.ybl = pick_sample();
    blk.ybr = pick_sample();
    blk.cb  = pick_sample();
    blk.cr  = pick_sample();
    return blk;
  endfunction

  // Leaves valid high after acceptance; the next call lowers it or reloads it.
  task automatic send_block(block_t blk);
    int gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      in_blk.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_blk.valid             <= 1'b1;
    in_blk.luma_top_left     <= blk.ytl;
    in_blk.luma_top_right    <= blk.ytr;
    in_blk.luma_bottom_left  <= blk.ybl;
    in_blk.luma_bottom_right <= blk.ybr;
    in_blk.chroma_blue       <= blk.cb;
    in_blk.chroma_red        <= blk.cr;
    do @(posedge clk); while (!in_blk.ready);
    book.note_block(blk);
  endtask

  task automatic send_random(int count);
    repeat (count) send_block(pick_block());
  endtask

  task automatic drain_results();
    while (book.pending_count() > 0) @(posedge clk);
  endtask

  initial begin
    int gap;
    out_blk.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_cycles > 0) begin
        out_blk.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      gap = $urandom_range(0, rx_idle_max);
      if (gap > 0) begin
        out_blk.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_blk.ready <= 1'b1;
      do @(posedge clk); while (out_blk.valid !== 1'b1);
      book.check_pairs(out_blk.top_pair, out_blk.bottom_pair);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_blk.valid && in_blk.ready) || (out_blk.valid && out_blk.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: watchdog, no request moved for %0d cycles", $time, QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n                    <= 1'b0;
    in_blk.valid             <= 1'b0;
    in_blk.luma_top_left     <= 8'd0;
    in_blk.luma_top_right    <= 8'd0;
    in_blk.luma_bottom_left  <= 8'd0;
    in_blk.luma_bottom_right <= 8'd0;
    in_blk.chroma_blue       <= 8'd0;
    in_blk.chroma_red        <= 8'd0;
    quiet_cycles             <= 0;
    hold_cycles = 0;
    tx_idle_max = 10;
    rx_idle_max = 10;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // neutral chroma, full clamps both ways, truncation next to zero, bit patterns
    send_block({8'd0,   8'd0,   8'd0,   8'd0,   8'd128, 8'd128});
    send_block({8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128});
    send_block({8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd0});
    send_block({8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd255});
    send_block({8'd128, 8'd128, 8'd128, 8'd128, 8'd0,   8'd255});
    send_block({8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd0});
    send_block({8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd255});
    send_block({8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0});
    send_block({8'd16,  8'd235, 8'd16,  8'd235, 8'd127, 8'd129});
    send_block({8'd235, 8'd16,  8'd235, 8'd16,  8'd129, 8'd127});
    send_block({8'h55,  8'haa,  8'h0f,  8'hf0,  8'h55,  8'haa});
    send_block({8'haa,  8'h55,  8'hf0,  8'h0f,  8'haa,  8'h55});
    send_block({8'd1,   8'd254, 8'd2,   8'd253, 8'd1,   8'd254});
    send_block({8'd200, 8'd60,  8'd100, 8'd30,  8'd64,  8'd192});
    send_block({8'd30,  8'd100, 8'd60,  8'd200, 8'd192, 8'd64});
    send_block({8'd255, 8'd255, 8'd0,   8'd0,   8'd128, 8'd255});
    send_block({8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd128});
    send_block({8'd4,   8'd8,   8'd3,   8'd7,   8'd128, 8'd128});

    send_random(400);

    // output held off while requests keep coming, so the pipe backs up
    tx_idle_max = 0;
    hold_cycles = HOLD_OFF_CYCLES;
    send_random(40);
    in_blk.valid <= 1'b0;
    drain_results();

    rx_idle_max = 0;
    send_random(400);
    tx_idle_max = 10;
    send_random(250);
    tx_idle_max = 0;
    rx_idle_max = 10;
    send_random(250);

    in_blk.valid <= 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d blocks sent, %0d row pairs checked across gapped, back-to-back",
             book.blocks_in, book.pairs_out);
    $display("and output hold-off phases; %0d errors, %0d results still pending",
             book.errors, book.pending_count());
    if (book.errors == 0 && book.pending_count() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
